// ----- design/cflb_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cflb_pkg
// Shared constants and types of the cross-faded loop buffer with cubic read.
// ---------------------------------------------------------------------------
package cflb_pkg;

  localparam int BufferSize = 4096;
  localparam int Guard      = 64;
  localparam int RawSize    = BufferSize + 2 * Guard;
  localparam int RGuard     = Guard - 2;
  localparam int DivConst   = 2 * RGuard;

  localparam int SampleW = 24;
  localparam int AddrW   = 13;
  localparam int PosW    = 29;
  localparam int FracW   = 16;
  localparam int SlotW   = 6;
  localparam int SpeedW  = 21;
  localparam int QW      = 17;
  localparam int NumW    = 29;
  localparam int MacAW   = 30;
  localparam int MacBW   = 18;
  localparam int MacPW   = 48;

  // zone weight quotient: n / DivConst = (n / 4) / 31, ceil(2^24 / 31)
  localparam int QuotW      = 16;
  localparam int DivLimit   = DivConst * 32768;
  localparam int RecipW     = 20;
  localparam int RecipMul   = 541201;
  localparam int RecipShift = 24;

  typedef enum logic [1:0] {
    CFG_LOOP_START = 2'd0,
    CFG_LOOP_END   = 2'd1,
    CFG_SPEED      = 2'd2
  } cfg_idx_e;

endpackage
`default_nettype wire

// ----- design/cflb_mac.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cflb_mac
// Shared multiply-add: p = a * b + c, registered.
// ---------------------------------------------------------------------------
module cflb_mac import cflb_pkg::*; (
  input  wire                     clk_i,
  input  wire logic signed [MacAW-1:0] a_i,
  input  wire logic signed [MacBW-1:0] b_i,
  input  wire logic signed [MacPW-1:0] c_i,
  output logic signed [MacPW-1:0] p_o
);

  logic signed [MacPW-1:0] prod;
  logic signed [MacPW-1:0] p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod + c_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ----- design/cflb_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cflb_div
// Division by the zone-weight constant by reciprocal multiply, registered.
// The quotient saturates at 2^15, beyond which the weight clamps anyway.
// ---------------------------------------------------------------------------
module cflb_div import cflb_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire logic [NumW-1:0] num_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quot_o
);

  logic                  run_q, done_q, big_q;
  logic [RecipW-1:0]     x_q;
  logic [2*RecipW-1:0]   prod;
  logic [QuotW-1:0]      quot_q;

  // exact for x below 2^20: the reciprocal error 15 times x stays under 2^24
  assign prod = x_q * RecipW'(RecipMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= start_i;
      done_q <= run_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= num_i[RecipW+1:2];
      big_q <= num_i >= NumW'(DivLimit);
    end
    if (run_q) begin
      quot_q <= big_q ? QuotW'(32768) : prod[RecipShift +: QuotW];
    end
  end

  assign done_o = done_q;
  assign quot_o = {{(NumW-QuotW){1'b0}}, quot_q};

endmodule
`default_nettype wire

// ----- design/crossfade_loop_buffer_cubic_read.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crossfade_loop_buffer_cubic_read
// Looping sample ring with cross-faded pushes and Catmull-Rom reads.
// ---------------------------------------------------------------------------
// Usage:
//   Input words on s_axis: tuser[0] selects push (0) or read (1), tdata holds
//   the sample to push. A push gives no output word; a read gives one
//   interpolated sample on m_axis. Loop bounds and speed are written on the
//   cfg channel (always ready) while the block is idle.
//   A push keeps the block busy while each of the GUARD faded entries gets a
//   fade read, a pass through the shared multiplier and up to two writes on
//   the single store port.
//   A read at an integer position gives its word from one store read;
//   otherwise each of four neighbors takes a store read, inside the loop
//   zones two store reads and two multiplies after the zone weight
//   division, and the three Horner steps follow on the shared multiplier.
//   One word is processed at a time; s_axis_tready is low while busy and the
//   next word can be taken in the cycle after the busy state ends.
//   After reset all 4224 store entries and the fade history are cleared, one
//   entry a cycle, before the first word is taken.
//   A finished result waits in the output register; a new word may be taken
//   meanwhile, and a second read result stalls until the first is taken.
// ---------------------------------------------------------------------------
module crossfade_loop_buffer_cubic_read import cflb_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [23:0]        s_axis_tdata,   // [23:0] sample_in
  input  wire logic [0:0]         s_axis_tuser,   // [0] mode
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  output logic [23:0]             m_axis_tdata,   // [23:0] sample_out
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [SpeedW-1:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_P_RD, S_P_FADE, S_P_FRD, S_P_MUL, S_P_WR, S_P_MIR,
    S_R_A, S_R_B, S_R_C, S_R_DIR, S_R_DIV, S_R_Q,
    S_N_RA, S_N_RB, S_N_M1, S_N_M2, S_N_ST,
    S_C1, S_C2, S_C3, S_C4, S_OUT
  } state_e;

  typedef enum logic [1:0] {Z_NONE, Z_START, Z_END} zone_e;

  state_e state_q;
  zone_e  zone_q;

  logic [AddrW-1:0]  clr_q, wp_q, ls_q, le_q;
  logic [SlotW-1:0]  slot_q, cnt_q;
  logic [PosW-1:0]   rp_q, pos_q;
  logic [SpeedW-1:0] spd_q;
  logic [SampleW-1:0] sample_q, v_q, a_q, b_q, res_q, out_q;
  logic [SampleW-1:0] x_q [4];
  logic [QW-1:0]     q_q;
  logic              neg_q, out_valid_q;

  // store and fade history
  logic [SampleW-1:0] store_mem [RawSize];
  logic [SampleW-1:0] fnew_mem [Guard];
  logic [SampleW-1:0] fold_mem [Guard];
  logic               st_we, st_oor, st_oor_q;
  logic signed [16:0] st_idx;
  logic [AddrW-1:0]   st_addr;
  logic [SampleW-1:0] st_wdata, st_rdata_q, st_rd;
  logic               fd_we;
  logic [SlotW-1:0]   fd_addr;
  logic [SampleW-1:0] fd_wnew, fd_wold, fnew_q, fold_q;

  assign st_addr = st_idx[AddrW-1:0];
  assign st_oor  = (st_idx < 17'sd0) || (st_idx >= 17'(RawSize));
  assign st_rd   = st_oor_q ? '0 : st_rdata_q;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_addr] <= st_wdata;
    end else begin
      st_rdata_q <= store_mem[st_addr];
    end
    st_oor_q <= st_oor;
    if (fd_we) begin
      fnew_mem[fd_addr] <= fd_wnew;
      fold_mem[fd_addr] <= fd_wold;
    end else begin
      fnew_q <= fnew_mem[fd_addr];
      fold_q <= fold_mem[fd_addr];
    end
  end

  // shared multiply-add and divider
  logic signed [MacAW-1:0] mac_a;
  logic signed [MacBW-1:0] mac_b;
  logic signed [MacPW-1:0] mac_c, mac_p;
  logic                    div_start, div_done;
  logic [NumW-1:0]         div_num, div_quot;

  cflb_mac u_mac (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .p_o   (mac_p)
  );

  cflb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // position arithmetic
  logic signed [31:0] pos_s, ls16, le16, len16, rg16, spd_s, numer, mag, qs;
  logic signed [16:0] len_s, nb_idx, tw_idx, k_idx;
  logic [FracW-1:0]   fr;
  logic [AddrW-1:0]   ip;

  assign pos_s = signed'({3'b0, pos_q});
  assign ls16  = signed'({3'b0, ls_q, 16'b0});
  assign le16  = signed'({3'b0, le_q, 16'b0});
  assign rg16  = 32'(RGuard * 65536);
  assign len16 = le16 - ls16 + 32'sd65536;
  assign spd_s = 32'(signed'(spd_q));
  assign fr    = pos_q[FracW-1:0];
  assign ip    = pos_q[PosW-1:FracW];
  assign numer = (zone_q == Z_START) ? (pos_s - ls16) : (le16 - pos_s);
  assign mag   = numer[31] ? -numer : numer;
  assign div_num = mag[NumW-1:0];
  assign qs    = 32'sd32768 + (neg_q ? -signed'({3'b0, div_quot}) : signed'({3'b0, div_quot}));
  assign len_s = signed'({4'b0, le_q}) - signed'({4'b0, ls_q}) + 17'sd1;
  assign nb_idx = signed'({4'b0, ip}) - 17'sd1 + signed'({15'b0, cnt_q[1:0]});
  assign tw_idx = nb_idx + ((zone_q == Z_START) ? len_s : -len_s);
  assign k_idx  = signed'({4'b0, wp_q}) - signed'({11'b0, cnt_q});

  // cubic coefficients (doubled)
  logic signed [SampleW-1:0] xm1, x0, x1, x2;
  logic signed [27:0] ca;
  logic signed [28:0] cb;
  logic signed [24:0] cc, fd_d;
  logic signed [25:0] fv;
  logic signed [31:0] rr;

  assign xm1 = signed'(x_q[0]);
  assign x0  = signed'(x_q[1]);
  assign x1  = signed'(x_q[2]);
  assign x2  = signed'(x_q[3]);
  assign ca  = 28'sd3 * (28'(x0) - 28'(x1)) - 28'(xm1) + 28'(x2);
  assign cb  = 29'sd4 * 29'(x1) + 29'sd2 * 29'(xm1) - 29'sd5 * 29'(x0) - 29'(x2);
  assign cc  = 25'(x1) - 25'(xm1);
  assign fd_d = 25'(signed'(fnew_q)) - 25'(signed'(fold_q));
  assign fv  = 26'(signed'(fold_q)) + 26'(signed'(mac_p[30:6]));
  assign rr  = 32'(x0) + 32'(signed'(mac_p[MacPW-1:17]));

  // memory and unit control
  always_comb begin
    st_we    = 1'b0;
    st_idx   = nb_idx;
    st_wdata = '0;
    fd_we    = 1'b0;
    fd_addr  = slot_q - cnt_q;
    fd_wnew  = '0;
    fd_wold  = '0;
    mac_a    = '0;
    mac_b    = '0;
    mac_c    = '0;
    div_start = 1'b0;
    case (state_q)
      S_CLR: begin
        st_we   = 1'b1;
        st_idx  = signed'({4'b0, clr_q});
        fd_we   = 1'b1;
        fd_addr = clr_q[SlotW-1:0];
      end
      S_P_RD: st_idx = signed'({4'b0, wp_q});
      S_P_FADE: begin
        fd_we   = 1'b1;
        fd_addr = slot_q;
        fd_wnew = sample_q;
        fd_wold = st_rd;
      end
      S_P_MUL: begin
        mac_a = 30'(fd_d);
        mac_b = signed'(18'(cnt_q) + 18'd1);
        mac_c = 48'sd32;
      end
      S_P_WR: begin
        st_we    = 1'b1;
        st_idx   = k_idx;
        st_wdata = fv[SampleW-1:0];
      end
      S_P_MIR: begin
        st_wdata = v_q;
        if (k_idx < 17'(2 * Guard)) begin
          st_we  = 1'b1;
          st_idx = k_idx + 17'(BufferSize);
        end else if (k_idx > 17'(BufferSize - 1)) begin
          st_we  = 1'b1;
          st_idx = k_idx - 17'(BufferSize);
        end
      end
      S_R_C: begin
        st_idx    = signed'({4'b0, ip});
        div_start = (fr != '0) && (zone_q != Z_NONE);
      end
      S_N_RB: st_idx = tw_idx;
      S_N_M1: begin
        mac_a = 30'(signed'(a_q));
        mac_b = signed'({1'b0, q_q});
        mac_c = 48'sd32768;
      end
      S_N_M2: begin
        mac_a = 30'(signed'(b_q));
        mac_b = signed'({1'b0, 17'd65536 - q_q});
        mac_c = mac_p;
      end
      S_C1: begin
        mac_a = 30'(ca);
        mac_b = signed'({2'b0, fr});
        mac_c = 48'(cb) <<< 16;
      end
      S_C2: begin
        mac_a = signed'(mac_p[45:16]);
        mac_b = signed'({2'b0, fr});
        mac_c = 48'(cc) <<< 16;
      end
      S_C3: begin
        mac_a = signed'(mac_p[45:16]);
        mac_b = signed'({2'b0, fr});
        mac_c = 48'sd65536;
      end
      default: ;
    endcase
  end

  logic s_acc, m_acc, out_load;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = out_valid_q && m_axis_tready;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      wp_q        <= AddrW'(Guard);
      slot_q      <= '0;
      rp_q        <= PosW'(Guard * 65536);
      ls_q        <= 13'd64;
      le_q        <= 13'd4159;
      spd_q       <= 21'd65536;
      cnt_q       <= '0;
      zone_q      <= Z_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LOOP_START: ls_q  <= cfg_data_i[AddrW-1:0];
          CFG_LOOP_END:   le_q  <= cfg_data_i[AddrW-1:0];
          CFG_SPEED:      spd_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (m_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 13'd1;
          if (clr_q == AddrW'(RawSize - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_acc) begin
            sample_q <= s_axis_tdata;
            pos_q    <= rp_q;
            cnt_q    <= '0;
            zone_q   <= Z_NONE;
            state_q  <= s_axis_tuser[0] ? S_R_A : S_P_RD;
          end
        end
        S_P_RD:   state_q <= S_P_FADE;
        S_P_FADE: state_q <= S_P_FRD;
        S_P_FRD:  state_q <= S_P_MUL;
        S_P_MUL:  state_q <= S_P_WR;
        S_P_WR: begin
          v_q     <= fv[SampleW-1:0];
          state_q <= S_P_MIR;
        end
        S_P_MIR: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == SlotW'(Guard - 1)) begin
            slot_q  <= slot_q + 6'd1;
            wp_q    <= (wp_q == AddrW'(RawSize - 1)) ? AddrW'(2 * Guard) : wp_q + 13'd1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_P_FRD;
          end
        end
        S_R_A: begin
          if (pos_s > le16 - rg16) begin
            if (pos_s > le16) begin
              pos_q  <= PosW'(pos_s - len16);
              zone_q <= Z_START;
            end else begin
              zone_q <= Z_END;
            end
          end
          state_q <= S_R_B;
        end
        S_R_B: begin
          if (pos_s < ls16 + rg16) begin
            if (pos_s < ls16) begin
              pos_q  <= PosW'(pos_s + len16);
              zone_q <= Z_END;
            end else begin
              zone_q <= Z_START;
            end
          end
          state_q <= S_R_C;
        end
        S_R_C: begin
          rp_q  <= PosW'(pos_s + spd_s);
          neg_q <= numer[31];
          q_q   <= '0;
          if (fr == '0) state_q <= S_R_DIR;
          else if (zone_q == Z_NONE) state_q <= S_N_RA;
          else state_q <= S_R_DIV;
        end
        S_R_DIR: begin
          res_q   <= st_rd;
          state_q <= S_OUT;
        end
        S_R_DIV: if (div_done) state_q <= S_R_Q;
        S_R_Q: begin
          if (qs < 32'sd0) q_q <= '0;
          else if (qs > 32'sd65536) q_q <= 17'd65536;
          else q_q <= qs[QW-1:0];
          state_q <= S_N_RA;
        end
        S_N_RA: state_q <= S_N_RB;
        S_N_RB: begin
          a_q <= st_rd;
          if (zone_q == Z_NONE) begin
            x_q[cnt_q[1:0]] <= st_rd;
            cnt_q   <= cnt_q + 6'd1;
            state_q <= (cnt_q[1:0] == 2'd3) ? S_C1 : S_N_RA;
          end else begin
            state_q <= S_N_M1;
          end
        end
        S_N_M1: begin
          b_q     <= st_rd;
          state_q <= S_N_M2;
        end
        S_N_M2: state_q <= S_N_ST;
        S_N_ST: begin
          x_q[cnt_q[1:0]] <= mac_p[39:16];
          cnt_q   <= cnt_q + 6'd1;
          state_q <= (cnt_q[1:0] == 2'd3) ? S_C1 : S_N_RA;
        end
        S_C1: state_q <= S_C2;
        S_C2: state_q <= S_C3;
        S_C3: state_q <= S_C4;
        S_C4: begin
          if (rr > 32'sd8388607) res_q <= 24'h7FFFFF;
          else if (rr < -32'sd8388608) res_q <= 24'h800000;
          else res_q <= rr[SampleW-1:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

// ----- verif/crossfade_loop_buffer_cubic_read_test.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crossfade_loop_buffer_cubic_read_test
// Self-checking bench for the cross-faded loop buffer with cubic reads.
// Pushes and reads go through the input stream with random gaps; a local
// model of the ring, fade history and read position predicts every output
// word. Loop bounds and speed are changed between phases while idle.
// ---------------------------------------------------------------------------
module crossfade_loop_buffer_cubic_read_test;
  import cflb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [SpeedW-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  crossfade_loop_buffer_cubic_read uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // ---- predictor state ----
  longint ring [RawSize];
  longint fnew [Guard];
  longint fold [Guard];
  longint wpos, slot, rpos;
  longint lstart, lend, step;
  logic [23:0] pending_samples [$];
  bit failed = 0;
  bit calm = 0;
  int idle_cnt = 0;

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint peek(longint idx);
    if (idx < 0 || idx >= RawSize) return 0;
    return ring[idx];
  endfunction

  function automatic void poke(longint idx, longint v);
    if (idx >= 0 && idx < RawSize) ring[idx] = v;
  endfunction

  function automatic void fade_push(longint s);
    longint j, k, d, v;
    if (slot >= Guard) slot = 0;
    fnew[slot] = s;
    fold[slot] = peek(wpos);
    j = slot;
    k = wpos;
    for (int i = 0; i < Guard; i++) begin
      if (j < 0) j += Guard;
      d = fnew[j] - fold[j];
      v = fold[j] + fdiv(2 * d * (i + 1) + Guard, 2 * Guard);
      poke(k, v);
      if (k < 2 * Guard) poke(k + BufferSize, v);
      if (k > BufferSize - 1) poke(k - BufferSize, v);
      j--;
      k--;
    end
    wpos++;
    if (wpos >= RawSize) wpos = 2 * Guard;
    slot++;
  endfunction

  function automatic longint blend(longint idx, int zone, longint twin, longint q);
    if (zone == 0) return peek(idx);
    return (peek(idx) * q + peek(idx + twin) * (65536 - q) + 32768) >>> 16;
  endfunction

  function automatic longint cubic_read();
    longint len, pos, ip, fr, q, twin, xm1, x0, x1, x2, a, b, c, t, r;
    int zone;
    len = lend - lstart + 1;
    pos = rpos;
    q = 0;
    twin = 0;
    zone = 0;
    if (pos > (lend - RGuard) * 65536) begin
      if (pos > lend * 65536) begin
        pos = (pos - len * 65536) & 64'h1FFF_FFFF;
        zone = 1;
      end else zone = 2;
    end
    if (pos < (lstart + RGuard) * 65536) begin
      if (pos < lstart * 65536) begin
        pos = (pos + len * 65536) & 64'h1FFF_FFFF;
        zone = 2;
      end else zone = 1;
    end
    ip = pos >> 16;
    fr = pos & 16'hFFFF;
    rpos = (pos + step) & 64'h1FFF_FFFF;
    if (fr == 0) return peek(ip);
    if (zone == 1) begin
      q = 32768 + (pos - lstart * 65536) / (2 * RGuard);
      twin = len;
    end else if (zone == 2) begin
      q = 32768 + (lend * 65536 - pos) / (2 * RGuard);
      twin = -len;
    end
    if (q < 0) q = 0;
    if (q > 65536) q = 65536;
    xm1 = blend(ip - 1, zone, twin, q);
    x0 = blend(ip, zone, twin, q);
    x1 = blend(ip + 1, zone, twin, q);
    x2 = blend(ip + 2, zone, twin, q);
    a = 3 * (x0 - x1) - xm1 + x2;
    b = 4 * x1 + 2 * xm1 - 5 * x0 - x2;
    c = x1 - xm1;
    t = (a * fr + b * 65536) >>> 16;
    t = (t * fr + c * 65536) >>> 16;
    t = t * fr;
    r = x0 + ((t + 65536) >>> 17);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 31);
  endfunction

  // ---- driving ----
  // tvalid stays up after an accept unless the next word idles first
  task automatic send_word(bit rd, logic [23:0] smp);
    bit acc;
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= rd;
    s_axis_tdata <= smp;
    // ready is stable between edges, so sample it at the preceding falling edge
    do begin
      @(negedge clk_i);
      acc = s_axis_tready;
      @(posedge clk_i);
    end while (!acc);
    if (rd) pending_samples.push_back(24'(cubic_read()));
    else fade_push(longint'($signed(smp)));
  endtask

  task automatic write_reg(cfg_idx_e idx, longint val);
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);  // a trailing push may still be fading
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= SpeedW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LOOP_START: lstart = val & 13'h1FFF;
      CFG_LOOP_END:   lend = val & 13'h1FFF;
      default:        step = longint'($signed(SpeedW'(val)));
    endcase
  endtask

  // ---- checking ----
  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= !idle_now();
  end

  // handshake seen at the falling edge before the edge that takes the word
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
        failed = 1;
      end else begin
        if (pending_samples[0] !== m_axis_tdata) begin
          $display("%0t: sample_out mismatch, expected %h, actual %h",
                   $time, pending_samples[0], m_axis_tdata);
          failed = 1;
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  typedef struct {
    bit rd;
    logic [23:0] smp;
    bit known;
    logic [23:0] want;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{1'b1, 24'h000000, 1'b1, 24'h000000},  // read after reset: cleared store
    '{1'b0, 24'h7FFFFF, 1'b0, 24'h0},
    '{1'b0, 24'h800000, 1'b0, 24'h0},
    '{1'b0, 24'hFFFFFF, 1'b0, 24'h0},
    '{1'b0, 24'h000001, 1'b0, 24'h0},
    '{1'b0, 24'h555555, 1'b0, 24'hAAAAAA},
    '{1'b0, 24'hAAAAAA, 1'b0, 24'h0},
    '{1'b1, 24'hFFFFFF, 1'b0, 24'h0},
    '{1'b1, 24'h000000, 1'b0, 24'h0},
    '{1'b0, 24'h7FFFFF, 1'b0, 24'h0},
    '{1'b1, 24'h000000, 1'b0, 24'h0}
  };

  // one phase: n random pushes and reads, about read_pct percent of them reads
  task automatic run_phase(int n, int read_pct);
    for (int i = 0; i < n; i++) begin
      logic [23:0] smp;
      smp = 24'($urandom());
      if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      send_word($urandom_range(99) < read_pct, smp);
    end
  endtask

  initial begin
    for (int i = 0; i < RawSize; i++) ring[i] = 0;
    for (int i = 0; i < Guard; i++) begin
      fnew[i] = 0;
      fold[i] = 0;
    end
    wpos = Guard;
    slot = 0;
    rpos = Guard * 65536;
    lstart = 64;
    lend = 4159;
    step = 65536;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].rd, dir_rows[i].smp);
      if (dir_rows[i].known && pending_samples[$] !== dir_rows[i].want) begin
        $display("%0t: row %0d table mismatch, expected %h, predicted %h",
                 $time, i, dir_rows[i].want, pending_samples[$]);
        failed = 1;
      end
    end

    // small loop in the pushed region, fractional speeds, zone blends
    write_reg(CFG_LOOP_START, 70);
    write_reg(CFG_LOOP_END, 200);
    write_reg(CFG_SPEED, 40000);
    run_phase(300, 40);
    calm = 1;
    write_reg(CFG_SPEED, -524288);
    run_phase(200, 50);
    calm = 0;
    write_reg(CFG_SPEED, 524288);
    write_reg(CFG_LOOP_START, 0);
    write_reg(CFG_LOOP_END, 4223);
    run_phase(200, 50);
    write_reg(CFG_SPEED, -(longint'($urandom_range(200000))));
    write_reg(CFG_LOOP_START, 4000);
    write_reg(CFG_LOOP_END, 4150);
    run_phase(200, 50);
    // odd bounds: end below start, out-of-store reads
    write_reg(CFG_LOOP_START, 300);
    write_reg(CFG_LOOP_END, 100);
    write_reg(CFG_SPEED, 12345);
    run_phase(150, 50);
    write_reg(CFG_LOOP_START, 8191);
    write_reg(CFG_LOOP_END, 8191);
    write_reg(CFG_SPEED, 70000);
    run_phase(100, 50);
    write_reg(CFG_LOOP_START, 64);
    write_reg(CFG_LOOP_END, 4159);
    write_reg(CFG_SPEED, $urandom_range(524288));
    run_phase(150, 40);

    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
